// ----- hw/rtl/tcp_flow_direction_segmenter_macros.svh -----
// Assertion macros used by the flow segmenter RTL.
// No dependencies; included by tfds_ctrl, the module that carries checks.
`ifndef TCP_FLOW_DIRECTION_SEGMENTER_MACROS_SVH
`define TCP_FLOW_DIRECTION_SEGMENTER_MACROS_SVH
`ifndef SYNTH
`define TFDS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tfds: same-cycle check failed");
`define TFDS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tfds: next-cycle check failed");
`else
`define TFDS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define TFDS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- hw/rtl/tfds_pkg.sv -----
// Shared types and constants of the TCP flow direction segmenter.
// No dependencies.
package tfds_pkg;

    localparam int TBL_DEPTH = 16;
    localparam int SLOT_W    = 4;

    typedef enum logic [2:0] {
        EV_CREATED = 3'd0,
        EV_FULL    = 3'd1,
        EV_EMPTY   = 3'd2,
        EV_NOCONN  = 3'd3,
        EV_START   = 3'd4,
        EV_CONT    = 3'd5,
        EV_END     = 3'd6
    } t_event;

    // direction codes kept per slot
    localparam logic [1:0] DIR_NEW = 2'd0;
    localparam logic [1:0] DIR_C2S = 2'd1;
    localparam logic [1:0] DIR_S2C = 2'd2;

    typedef struct packed {
        logic        is_tcp;
        logic [63:0] src_ip_hi;
        logic [63:0] src_ip_lo;
        logic [63:0] dst_ip_hi;
        logic [63:0] dst_ip_lo;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic        syn;
        logic        ack;
        logic        fin;
        logic        rst_req;
        logic        has_payload;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        event_res;
        logic [SLOT_W-1:0] slot;
        logic              direction;
        logic              last;
    } t_out_item;

    // connection tuple stored per slot
    typedef struct packed {
        logic [63:0] cli_hi;
        logic [63:0] cli_lo;
        logic [63:0] srv_hi;
        logic [63:0] srv_lo;
        logic [15:0] cli_port;
        logic [15:0] srv_port;
    } t_tuple;

    // write request from the sequencer into the table
    typedef struct packed {
        logic              tup_we;
        logic              prev_we;
        logic [SLOT_W-1:0] addr;
        t_tuple            tuple;
        logic [1:0]        prev;
    } t_tbl_wr;

endpackage

// ----- hw/rtl/tcp_flow_direction_segmenter.sv -----
// TCP flow direction segmenter: tracks up to NUM_CONN connections in a
// slot table and turns TCP segments into stream start/continue/end events.
// A SYN-only, empty or table-full segment has its result held as pending and
// moved to the output register in S_FIN. A data or FIN segment walks the
// table one slot at a time through the single table read port: a free slot
// takes a read step, an occupied slot a read and a compare, each event takes
// its own step, and the walk closes with an end check and finish, or FIN or
// RST stops the walk early. Output stalls hold the event and finish steps.
// One item is processed at a time; results leave through a registered output.
// Depends on tfds_pkg, tfds_ctrl and tfds_tbl.
module tcp_flow_direction_segmenter #(
    parameter int NUM_CONN = tfds_pkg::TBL_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  tfds_pkg::t_in_item  i_in_item,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output tfds_pkg::t_out_item o_out_item,
    input  logic                i_out_stall
);
    import tfds_pkg::*;

    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    t_tuple            rd_tuple;
    logic [1:0]        rd_prev;
    t_tbl_wr           wr;

    tfds_ctrl #(.NUM_CONN(NUM_CONN)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_tuple  (rd_tuple),
        .i_rd_prev   (rd_prev),
        .o_wr        (wr)
    );

    tfds_tbl #(.NUM_CONN(NUM_CONN)) u_tbl (
        .i_clk      (i_clk),
        .i_rd_en    (rd_en),
        .i_rd_addr  (rd_addr),
        .i_wr       (wr),
        .o_rd_tuple (rd_tuple),
        .o_rd_prev  (rd_prev)
    );

endmodule

// ----- hw/rtl/tfds_tbl.sv -----
// Connection table: tuple memory and direction memory, one read port each.
// Depends on tfds_pkg.
module tfds_tbl #(
    parameter int NUM_CONN = tfds_pkg::TBL_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rd_en,
    input  logic [tfds_pkg::SLOT_W-1:0] i_rd_addr,
    input  tfds_pkg::t_tbl_wr           i_wr,
    output tfds_pkg::t_tuple            o_rd_tuple,
    output logic [1:0]                  o_rd_prev
);
    import tfds_pkg::*;

    t_tuple     r_tup_mem  [NUM_CONN];
    logic [1:0] r_prev_mem [NUM_CONN];
    t_tuple     r_rd_tuple;
    logic [1:0] r_rd_prev;

    // tuple memory
    always_ff @(posedge i_clk) begin
        if (i_wr.tup_we) begin
            r_tup_mem[i_wr.addr] <= i_wr.tuple;
        end
        if (i_rd_en) begin
            r_rd_tuple <= r_tup_mem[i_rd_addr];
        end
    end

    // previous-direction memory
    always_ff @(posedge i_clk) begin
        if (i_wr.prev_we) begin
            r_prev_mem[i_wr.addr] <= i_wr.prev;
        end
        if (i_rd_en) begin
            r_rd_prev <= r_prev_mem[i_rd_addr];
        end
    end

    assign o_rd_tuple = r_rd_tuple;
    assign o_rd_prev  = r_rd_prev;

endmodule

// ----- hw/rtl/tfds_ctrl.sv -----
// Sequencer: insert, slot walk, event generation and output register.
// Depends on tfds_pkg and the assertion macro header.
`include "tcp_flow_direction_segmenter_macros.svh"
module tfds_ctrl #(
    parameter int NUM_CONN = tfds_pkg::TBL_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  tfds_pkg::t_in_item          i_in_item,
    output logic                        o_in_stall,
    output logic                        o_out_valid,
    output tfds_pkg::t_out_item         o_out_item,
    input  logic                        i_out_stall,
    output logic                        o_rd_en,
    output logic [tfds_pkg::SLOT_W-1:0] o_rd_addr,
    input  tfds_pkg::t_tuple            i_rd_tuple,
    input  logic [1:0]                  i_rd_prev,
    output tfds_pkg::t_tbl_wr           o_wr
);
    import tfds_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_RD     = 7'b0000010,
        S_CMP    = 7'b0000100,
        S_ENDOLD = 7'b0001000,
        S_NEWSTR = 7'b0010000,
        S_ENDCUR = 7'b0100000,
        S_FIN    = 7'b1000000
    } t_state;

    t_state              r_state, n_state;
    t_in_item            r_item, n_item;
    logic [SLOT_W:0]     r_slot, n_slot;
    logic [NUM_CONN-1:0] r_valid, n_valid;
    logic [1:0]          r_dcode, n_dcode;
    logic [1:0]          r_prev, n_prev;
    logic                r_pend_v, n_pend_v;
    t_out_item           r_pend, n_pend;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out, n_out;

    logic              in_acc;
    logic              out_free;
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    logic [SLOT_W-1:0] idx;
    logic              at_end;
    logic              c2s_ports;
    logic              c2s_hit;
    logic              s2c_hit;
    logic              end_flag;
    logic              dir_bit;
    logic              emit_v;
    t_out_item         emit_item;

    assign in_acc    = i_in_valid && (r_state == S_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign idx       = r_slot[SLOT_W-1:0];
    assign at_end    = (r_slot == (SLOT_W+1)'(NUM_CONN));
    assign end_flag  = r_item.fin || r_item.rst_req;
    assign dir_bit   = (r_dcode == DIR_S2C);
    assign o_rd_en   = (r_state == S_RD) && !at_end;
    assign o_rd_addr = idx;

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_CONN - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    // tuple compare against the slot just read
    assign c2s_ports = (r_item.src_port == i_rd_tuple.cli_port)
                    && (r_item.dst_port == i_rd_tuple.srv_port);
    assign c2s_hit = c2s_ports
                  && (r_item.src_ip_hi == i_rd_tuple.cli_hi)
                  && (r_item.src_ip_lo == i_rd_tuple.cli_lo)
                  && (r_item.dst_ip_hi == i_rd_tuple.srv_hi)
                  && (r_item.dst_ip_lo == i_rd_tuple.srv_lo);
    assign s2c_hit = !c2s_ports
                  && (r_item.src_port == i_rd_tuple.srv_port)
                  && (r_item.dst_port == i_rd_tuple.cli_port)
                  && (r_item.src_ip_hi == i_rd_tuple.srv_hi)
                  && (r_item.src_ip_lo == i_rd_tuple.srv_lo)
                  && (r_item.dst_ip_hi == i_rd_tuple.cli_hi)
                  && (r_item.dst_ip_lo == i_rd_tuple.cli_lo);

    // next-state logic; one event a cycle unless the output stalls, held one deep so last can be set
    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_slot      = r_slot;
        n_valid     = r_valid;
        n_dcode     = r_dcode;
        n_prev      = r_prev;
        n_pend_v    = r_pend_v;
        n_pend      = r_pend;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        emit_v      = 1'b0;
        emit_item   = '0;
        o_wr        = '0;
        o_wr.tuple  = {r_item.src_ip_hi, r_item.src_ip_lo, r_item.dst_ip_hi,
                       r_item.dst_ip_lo, r_item.src_port, r_item.dst_port};
        o_wr.addr   = idx;
        o_wr.prev   = r_dcode;

        case (r_state)
            S_IDLE: begin
                if (in_acc && i_in_item.is_tcp) begin
                    n_item = i_in_item;
                    n_slot = '0;
                    if (i_in_item.syn && !i_in_item.ack) begin
                        n_pend_v = 1'b1;
                        n_pend   = '0;
                        n_state  = S_FIN;
                        if (free_found) begin
                            n_valid[free_idx] = 1'b1;
                            o_wr.tup_we       = 1'b1;
                            o_wr.prev_we      = 1'b1;
                            o_wr.addr         = free_idx;
                            o_wr.prev         = DIR_NEW;
                            o_wr.tuple        = {i_in_item.src_ip_hi, i_in_item.src_ip_lo,
                                                 i_in_item.dst_ip_hi, i_in_item.dst_ip_lo,
                                                 i_in_item.src_port, i_in_item.dst_port};
                            n_pend.event_res  = EV_CREATED;
                            n_pend.slot       = free_idx;
                        end else begin
                            n_pend.event_res  = EV_FULL;
                        end
                    end else if (!i_in_item.fin && !i_in_item.has_payload) begin
                        n_pend_v         = 1'b1;
                        n_pend           = '0;
                        n_pend.event_res = EV_EMPTY;
                        n_state          = S_FIN;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                if (at_end) begin
                    n_state = S_FIN;
                end else if (r_valid[idx]) begin
                    n_state = S_CMP;
                end else begin
                    n_slot = r_slot + 1'b1;
                end
            end
            S_CMP: begin
                if (c2s_hit || s2c_hit) begin
                    n_dcode = c2s_hit ? DIR_C2S : DIR_S2C;
                    n_prev  = i_rd_prev;
                    if ((i_rd_prev != n_dcode)
                        && (i_rd_prev == DIR_C2S || i_rd_prev == DIR_S2C)) begin
                        n_state = S_ENDOLD;
                    end else begin
                        n_state = S_NEWSTR;
                    end
                end else begin
                    n_slot  = r_slot + 1'b1;
                    n_state = S_RD;
                end
            end
            S_ENDOLD: begin
                if (out_free) begin
                    emit_v              = 1'b1;
                    emit_item.event_res = EV_END;
                    emit_item.slot      = idx;
                    emit_item.direction = !dir_bit;
                    n_state             = S_NEWSTR;
                end
            end
            S_NEWSTR: begin
                if (out_free) begin
                    emit_v              = 1'b1;
                    emit_item.event_res = (r_prev == r_dcode) ? EV_CONT : EV_START;
                    emit_item.slot      = idx;
                    emit_item.direction = dir_bit;
                    o_wr.prev_we        = 1'b1;
                    if (end_flag) begin
                        n_state = S_ENDCUR;
                    end else begin
                        n_slot  = r_slot + 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            S_ENDCUR: begin
                if (out_free) begin
                    emit_v              = 1'b1;
                    emit_item.event_res = EV_END;
                    emit_item.slot      = idx;
                    emit_item.direction = dir_bit;
                    n_state             = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_pend_v) begin
                        n_out = r_pend;
                    end else begin
                        n_out           = '0;
                        n_out.event_res = EV_NOCONN;
                    end
                    n_out.last = 1'b1;
                    n_pend_v   = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // push the held event out and keep the new one
        if (emit_v) begin
            if (r_pend_v) begin
                n_out_valid = 1'b1;
                n_out       = r_pend;
                n_out.last  = 1'b0;
            end
            n_pend_v = 1'b1;
            n_pend   = emit_item;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_pend_v    <= n_pend_v;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_item  <= n_item;
        r_slot  <= n_slot;
        r_dcode <= n_dcode;
        r_prev  <= n_prev;
        r_pend  <= n_pend;
        r_out   <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `TFDS_ASSERT_IMP(a_idle_no_pend, i_clk, i_rst_n, r_state == S_IDLE, !r_pend_v)
    `TFDS_ASSERT_IMP(a_emit_dir, i_clk, i_rst_n,
        r_state == S_NEWSTR || r_state == S_ENDOLD || r_state == S_ENDCUR,
        r_dcode == DIR_C2S || r_dcode == DIR_S2C)
    `TFDS_ASSERT_NXT(a_non_tcp_idle, i_clk, i_rst_n, in_acc && !i_in_item.is_tcp,
        r_state == S_IDLE)
    `TFDS_ASSERT_IMP(a_fin_leaves, i_clk, i_rst_n, r_state == S_FIN && out_free,
        n_state == S_IDLE && n_out_valid)

endmodule
